// ----- rtl/lct_pkg.sv -----
// ----------------------------------------------------------------------------
// lct_pkg
// Shared types and constants for the link connectivity table unit: field
// widths, item mode codes, configuration register indexes, sequencer states.
// ----------------------------------------------------------------------------
package lct_pkg;

  // Default sizing of the table
  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;

  // Fixed field widths on the channels
  localparam int MODE_W    = 3;
  localparam int SLOT_W    = 4;
  localparam int HP_W      = 16;
  localparam int ACK_W     = 16;
  localparam int ROW_OUT_W = 16;
  localparam int LIMIT_W   = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MY_SLOT      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE_LIMIT = 1'd1;

  localparam logic [SLOT_W-1:0]  MY_SLOT_RST      = 4'd0;
  localparam logic [LIMIT_W-1:0] EXPIRE_LIMIT_RST = 16'd4;

  // Item modes; codes 6 and 7 are unused and only read the row
  typedef enum logic [MODE_W-1:0] {
    MODE_HEARD_FROM  = 3'd0,
    MODE_ACK_ROW     = 3'd1,
    MODE_COVER       = 3'd2,
    MODE_UNION_COVER = 3'd3,
    MODE_EXPIRE      = 3'd4,
    MODE_READ_ROW    = 3'd5
  } mode_t;

  // Item sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_B,
    ST_RD_MY,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/lct_item_if.sv -----
// ----------------------------------------------------------------------------
// lct_item_if
// Valid/ready channel carrying one table update or query item.
// ----------------------------------------------------------------------------
interface lct_item_if;

  logic                         valid;
  logic                         ready;
  logic [lct_pkg::MODE_W-1:0]   mode;
  logic [lct_pkg::SLOT_W-1:0]   slot_id;
  logic [lct_pkg::SLOT_W-1:0]   other_slot_id;
  logic [lct_pkg::HP_W-1:0]     hyperperiod;
  logic [lct_pkg::ACK_W-1:0]    ack_row;

  modport source (
    output valid, mode, slot_id, other_slot_id, hyperperiod, ack_row,
    input  ready
  );

  modport sink (
    input  valid, mode, slot_id, other_slot_id, hyperperiod, ack_row,
    output ready
  );

endinterface

// ----- rtl/lct_result_if.sv -----
// ----------------------------------------------------------------------------
// lct_result_if
// Valid/ready channel carrying one result: coverage flag and own row.
// ----------------------------------------------------------------------------
interface lct_result_if;

  logic                            valid;
  logic                            ready;
  logic                            covered;
  logic [lct_pkg::ROW_OUT_W-1:0]   my_row_bits;

  modport source (
    output valid, covered, my_row_bits,
    input  ready
  );

  modport sink (
    input  valid, covered, my_row_bits,
    output ready
  );

endinterface

// ----- rtl/lct_ram.sv -----
// ----------------------------------------------------------------------------
// lct_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (holds while re is low).
// ----------------------------------------------------------------------------
module lct_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/link_connectivity_table_unit.sv -----
// ----------------------------------------------------------------------------
// link_connectivity_table_unit
// TDMA mesh connectivity table: one reachability row per slot and a
// last-heard hyperperiod per slot, both held in RAM with valid bits.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Payload
//  item      in   valid/ready    mode, slot_id, other_slot_id, hyperperiod, ack_row
//  result    out  valid/ready    covered, my_row_bits
//  cfg       in   cfg_we only    cfg_idx, cfg_data (my_slot, expire_limit)
//
//  One item at a time through a short read-modify-write sequencer on the row
//  RAM read port: heard_from, ack_row, read_row go straight to ST_DONE, cover
//  via ST_RD_MY, union_cover via ST_RD_B and ST_RD_MY, expire via ST_SCAN (one
//  last-heard entry per cycle). Reset (rst, synchronous) clears the valid bits,
//  so rows read as self-only and times as zero at once; no clearing pass.
//  A held result register decouples the sides: a new item is taken while a
//  result waits; the sequencer stalls in its final step only while it is full.
//
module link_connectivity_table_unit #(
  parameter int NUM_SLOTS = lct_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = lct_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [lct_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [lct_pkg::CFG_DATA_W-1:0]  cfg_data,
  lct_item_if.sink                        item,
  lct_result_if.source                    result
);

  localparam int AW = $clog2(NUM_SLOTS);
  localparam logic [AW-1:0]        LAST_IDX = AW'(NUM_SLOTS - 1);
  localparam logic [NUM_SLOTS-1:0] ROW_ONE  = NUM_SLOTS'(1);

  // Slot field range check and address conversion
  function automatic logic slot_ok(input logic [lct_pkg::SLOT_W-1:0] s);
    return 32'(s) < NUM_SLOTS;
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [lct_pkg::SLOT_W-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[AW-1:0];
  endfunction

  // Configuration registers
  logic [lct_pkg::SLOT_W-1:0]  my_slot;
  logic [lct_pkg::LIMIT_W-1:0] expire_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      my_slot      <= lct_pkg::MY_SLOT_RST;
      expire_limit <= lct_pkg::EXPIRE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lct_pkg::CFG_MY_SLOT:      my_slot      <= cfg_data[lct_pkg::SLOT_W-1:0];
        lct_pkg::CFG_EXPIRE_LIMIT: expire_limit <= cfg_data[lct_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic          my_ok;
  logic [AW-1:0] my_addr;
  assign my_ok   = slot_ok(my_slot);
  assign my_addr = slot_addr(my_slot);

  // Sequencer state and latched item
  lct_pkg::state_t state, state_next;

  logic [lct_pkg::MODE_W-1:0] mode_q;
  logic [lct_pkg::SLOT_W-1:0] sa_q;
  logic [lct_pkg::SLOT_W-1:0] sb_q;
  logic [TIME_BITS-1:0]       hp_q;
  logic [NUM_SLOTS-1:0]       ack_q;
  logic [31:0]                hp_wide;
  logic [31:0]                ack_wide;
  logic                       load_item;

  assign hp_wide  = 32'(item.hyperperiod);
  assign ack_wide = 32'(item.ack_row);

  // RAM ports
  logic                 row_we, row_re;
  logic [AW-1:0]        row_waddr, row_raddr;
  logic [NUM_SLOTS-1:0] row_wdata, row_rdata;
  logic                 row_rd_ok;
  logic                 time_we, time_re;
  logic [AW-1:0]        time_waddr, time_raddr;
  logic [TIME_BITS-1:0] time_wdata, time_rdata;

  lct_ram #(.WIDTH(NUM_SLOTS), .DEPTH(NUM_SLOTS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  lct_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_SLOTS)) u_time_ram (
    .clk   (clk),
    .we    (time_we),
    .waddr (time_waddr),
    .wdata (time_wdata),
    .re    (time_re),
    .raddr (time_raddr),
    .rdata (time_rdata)
  );

  // Valid bits: an unwritten row reads self-only, an unwritten time reads zero
  logic [NUM_SLOTS-1:0] row_vld, time_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld  <= '0;
      time_vld <= '0;
    end else begin
      if (row_we) begin
        row_vld[row_waddr] <= 1'b1;
      end
      if (time_we) begin
        time_vld[time_waddr] <= 1'b1;
      end
    end
  end

  // Read-side tags follow the registered read data
  logic [AW-1:0] row_rd_addr_q;
  logic          row_rd_ok_q, row_rd_vld_q;
  logic [AW-1:0] t_idx;
  logic          time_rd_vld_q;

  always_ff @(posedge clk) begin
    if (row_re) begin
      row_rd_addr_q <= row_raddr;
      row_rd_ok_q   <= row_rd_ok;
      row_rd_vld_q  <= row_vld[row_raddr];
    end
    if (time_re) begin
      t_idx         <= time_raddr;
      time_rd_vld_q <= time_vld[time_raddr];
    end
  end

  logic [NUM_SLOTS-1:0] row_eff;
  logic [TIME_BITS-1:0] time_eff;
  logic [TIME_BITS-1:0] age;

  assign row_eff  = !row_rd_ok_q ? '0 :
                    (row_rd_vld_q ? row_rdata : (ROW_ONE << row_rd_addr_q));
  assign time_eff = time_rd_vld_q ? time_rdata : '0;
  assign age      = hp_q - time_eff;

  // Held rows for coverage queries and the expire clear mask
  logic [NUM_SLOTS-1:0] row_a, row_b, clr_mask;
  logic                 cap_a, cap_b, clr_set;

  // Result register
  logic                          out_valid, out_free, out_load;
  logic                          out_covered, covered_next;
  logic [lct_pkg::ROW_OUT_W-1:0] out_row, row_out_next;

  assign out_free = !out_valid || result.ready;

  // Final-step values
  logic                 sa_ok;
  logic [AW-1:0]        sa_addr;
  logic [NUM_SLOTS-1:0] my_new;
  logic [31:0]          my_new_wide;

  assign sa_ok       = slot_ok(sa_q);
  assign sa_addr     = slot_addr(sa_q);
  assign my_new_wide = 32'(my_new);
  assign row_out_next = my_new_wide[lct_pkg::ROW_OUT_W-1:0];

  assign item.ready = (state == lct_pkg::ST_IDLE);

  // Next state, RAM control and results
  always_comb begin
    state_next   = state;
    load_item    = 1'b0;
    row_re       = 1'b0;
    row_raddr    = my_addr;
    row_rd_ok    = my_ok;
    row_we       = 1'b0;
    row_waddr    = my_addr;
    row_wdata    = row_eff;
    time_re      = 1'b0;
    time_raddr   = '0;
    time_we      = 1'b0;
    time_waddr   = sa_addr;
    time_wdata   = hp_q;
    cap_a        = 1'b0;
    cap_b        = 1'b0;
    clr_set      = 1'b0;
    out_load     = 1'b0;
    covered_next = 1'b0;
    my_new       = row_eff;

    unique case (state)
      lct_pkg::ST_IDLE: begin
        if (item.valid) begin
          load_item = 1'b1;
          row_re    = 1'b1;
          unique case (item.mode)
            lct_pkg::MODE_COVER: begin
              row_raddr  = slot_addr(item.slot_id);
              row_rd_ok  = slot_ok(item.slot_id);
              state_next = lct_pkg::ST_RD_MY;
            end
            lct_pkg::MODE_UNION_COVER: begin
              row_raddr  = slot_addr(item.slot_id);
              row_rd_ok  = slot_ok(item.slot_id);
              state_next = lct_pkg::ST_RD_B;
            end
            lct_pkg::MODE_ACK_ROW: begin
              // write the peer row now; own row read is forwarded if it matches
              row_we     = slot_ok(item.slot_id);
              row_waddr  = slot_addr(item.slot_id);
              row_wdata  = ack_wide[NUM_SLOTS-1:0];
              state_next = lct_pkg::ST_DONE;
            end
            lct_pkg::MODE_EXPIRE: begin
              time_re    = 1'b1;
              state_next = lct_pkg::ST_SCAN;
            end
            default: begin
              state_next = lct_pkg::ST_DONE;
            end
          endcase
        end
      end

      lct_pkg::ST_RD_B: begin
        cap_a      = 1'b1;
        row_re     = 1'b1;
        row_raddr  = slot_addr(sb_q);
        row_rd_ok  = slot_ok(sb_q);
        state_next = lct_pkg::ST_RD_MY;
      end

      lct_pkg::ST_RD_MY: begin
        cap_a      = (mode_q != lct_pkg::MODE_UNION_COVER);
        cap_b      = (mode_q == lct_pkg::MODE_UNION_COVER);
        row_re     = 1'b1;
        state_next = lct_pkg::ST_DONE;
      end

      lct_pkg::ST_SCAN: begin
        // one last-heard entry per cycle; own slot never expires
        clr_set = (32'(age) > 32'(expire_limit)) && (32'(t_idx) != 32'(my_slot));
        if (t_idx == LAST_IDX) begin
          state_next = lct_pkg::ST_DONE;
        end else begin
          time_re    = 1'b1;
          time_raddr = t_idx + AW'(1);
        end
      end

      lct_pkg::ST_DONE: begin
        unique case (mode_q)
          lct_pkg::MODE_HEARD_FROM: begin
            // an out-of-range own slot keeps an empty row
            my_new = (my_ok && sa_ok) ? (row_eff | (ROW_ONE << sa_addr)) : row_eff;
            if (out_free) begin
              row_we  = my_ok && sa_ok;
              time_we = sa_ok;
            end
          end
          lct_pkg::MODE_ACK_ROW: begin
            my_new = (my_ok && sa_ok && (sa_addr == my_addr)) ? ack_q : row_eff;
          end
          lct_pkg::MODE_COVER: begin
            covered_next = ((row_eff & ~row_a) == '0);
          end
          lct_pkg::MODE_UNION_COVER: begin
            covered_next = ((row_eff & ~(row_a | row_b)) == '0);
          end
          lct_pkg::MODE_EXPIRE: begin
            my_new = row_eff & ~clr_mask;
            if (out_free) begin
              row_we = my_ok;
            end
          end
          default: ;
        endcase
        row_wdata = my_new;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = lct_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = lct_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lct_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item and working registers
  always_ff @(posedge clk) begin
    if (load_item) begin
      mode_q   <= item.mode;
      sa_q     <= item.slot_id;
      sb_q     <= item.other_slot_id;
      hp_q     <= hp_wide[TIME_BITS-1:0];
      ack_q    <= ack_wide[NUM_SLOTS-1:0];
      clr_mask <= '0;
    end else if (clr_set) begin
      clr_mask[t_idx] <= 1'b1;
    end
    if (cap_a) begin
      row_a <= row_eff;
    end
    if (cap_b) begin
      row_b <= row_eff;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_covered <= covered_next;
      out_row     <= row_out_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.covered     = out_covered;
  assign result.my_row_bits = out_row;

`ifndef NO_ASSERTIONS
  // Row RAM is written only at item acceptance (ack_row) or in the final step
  a_row_we_phase: assert property (@(posedge clk) disable iff (rst)
    row_we |-> (state == lct_pkg::ST_DONE) ||
               (state == lct_pkg::ST_IDLE && item.valid))
    else $error("row RAM written outside accept or final step");

  // An accepted item always moves the sequencer out of idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> (state != lct_pkg::ST_IDLE))
    else $error("sequencer stayed idle after accepting an item");

  // A new result only appears after the final step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == lct_pkg::ST_DONE))
    else $error("result raised outside final step");

  // Time RAM is never read and written in the same cycle
  a_time_port: assert property (@(posedge clk) disable iff (rst)
    !(time_we && time_re))
    else $error("time RAM read and write overlap");

  // Scan index stays within the table
  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    (state == lct_pkg::ST_SCAN) |-> (32'(t_idx) < NUM_SLOTS))
    else $error("expire scan index out of range");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the link connectivity table unit. A directed table
// walks the row extremes, every mode, wrapped ages and the unused mode codes;
// random phases then run heard/ack/cover/expire traffic under several
// my_slot / expire_limit settings with bursty idling on both channels. Every
// result is compared with its typed answer or this bench's shadow table.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NSLOT      = lct_pkg::NUM_SLOTS_DEF;
  localparam int DIR_LEN    = 24;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_LEN  = 150;

  // unused mode codes, only read the row
  localparam logic [lct_pkg::MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [lct_pkg::MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [lct_pkg::MODE_W-1:0] mode;
    logic [lct_pkg::SLOT_W-1:0] slot_id;
    logic [lct_pkg::SLOT_W-1:0] other_slot_id;
    logic [lct_pkg::HP_W-1:0]   hyperperiod;
    logic [lct_pkg::ACK_W-1:0]  ack_row;
  } item_t;

  typedef struct packed {
    logic                          covered;
    logic [lct_pkg::ROW_OUT_W-1:0] my_row;
  } report_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    report_t rep;
  } dir_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [lct_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [lct_pkg::CFG_DATA_W-1:0] cfg_data;

  lct_item_if   item_ch ();
  lct_result_if res_ch ();

  link_connectivity_table_unit dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .item     (item_ch),
    .result   (res_ch)
  );

  // Shadow of the table and its settings
  logic [NSLOT-1:0]             link_rows [NSLOT];
  logic [lct_pkg::HP_W-1:0]     heard_hp  [NSLOT];
  logic [lct_pkg::SLOT_W-1:0]   own_slot;
  logic [lct_pkg::LIMIT_W-1:0]  drop_limit;

  report_t row_reports_q [$];
  int outstanding;
  int mismatches;
  int mode_seen [8];
  int covered_hits;
  int settings_used;
  bit idle_on;
  int stall_left;
  logic [lct_pkg::HP_W-1:0] cur_hp;

  // Directed rows; typed rows carry their answer, the rest use the shadow
  dir_row_t directed_rows [DIR_LEN] = '{
    '{'{lct_pkg::MODE_READ_ROW,    4'd0,  4'd0,  16'h0000, 16'h0000}, 1'b1, '{1'b0, 16'h0001}},
    '{'{lct_pkg::MODE_COVER,       4'd0,  4'd0,  16'h0000, 16'h0000}, 1'b1, '{1'b1, 16'h0001}},
    '{'{lct_pkg::MODE_COVER,       4'd5,  4'd0,  16'h0000, 16'h0000}, 1'b1, '{1'b0, 16'h0001}},
    '{'{lct_pkg::MODE_UNION_COVER, 4'd5,  4'd0,  16'h0000, 16'h0000}, 1'b1, '{1'b1, 16'h0001}},
    '{'{lct_pkg::MODE_HEARD_FROM,  4'd15, 4'd0,  16'hFFFF, 16'h0000}, 1'b1, '{1'b0, 16'h8001}},
    '{'{lct_pkg::MODE_HEARD_FROM,  4'd0,  4'd15, 16'h0000, 16'hFFFF}, 1'b1, '{1'b0, 16'h8001}},
    '{'{lct_pkg::MODE_ACK_ROW,     4'd3,  4'd0,  16'h0000, 16'hFFFF}, 1'b1, '{1'b0, 16'h8001}},
    '{'{lct_pkg::MODE_COVER,       4'd3,  4'd0,  16'h0000, 16'h0000}, 1'b1, '{1'b1, 16'h8001}},
    '{'{lct_pkg::MODE_ACK_ROW,     4'd4,  4'd0,  16'h0000, 16'h0000}, 1'b1, '{1'b0, 16'h8001}},
    '{'{lct_pkg::MODE_UNION_COVER, 4'd4,  4'd15, 16'h0000, 16'h0000}, 1'b1, '{1'b0, 16'h8001}},
    '{'{lct_pkg::MODE_UNION_COVER, 4'd15, 4'd3,  16'h0000, 16'h0000}, 1'b1, '{1'b1, 16'h8001}},
    // age wraps to exactly the limit: kept; one more: dropped
    '{'{lct_pkg::MODE_EXPIRE,      4'd0,  4'd0,  16'h0003, 16'h0000}, 1'b1, '{1'b0, 16'h8001}},
    '{'{lct_pkg::MODE_EXPIRE,      4'd0,  4'd0,  16'h0004, 16'h0000}, 1'b1, '{1'b0, 16'h0001}},
    '{'{MODE_SPARE_6,              4'd9,  4'd9,  16'hFFFF, 16'hFFFF}, 1'b1, '{1'b0, 16'h0001}},
    '{'{MODE_SPARE_7,              4'd15, 4'd15, 16'h0000, 16'h0000}, 1'b1, '{1'b0, 16'h0001}},
    // ack aimed at our own slot overwrites our row
    '{'{lct_pkg::MODE_ACK_ROW,     4'd0,  4'd0,  16'h0000, 16'hA5A5}, 1'b1, '{1'b0, 16'hA5A5}},
    '{'{lct_pkg::MODE_COVER,       4'd3,  4'd0,  16'h0000, 16'h0000}, 1'b1, '{1'b1, 16'hA5A5}},
    '{'{lct_pkg::MODE_EXPIRE,      4'd0,  4'd0,  16'hFFFF, 16'h0000}, 1'b1, '{1'b0, 16'h8001}},
    '{'{lct_pkg::MODE_HEARD_FROM,  4'd7,  4'd0,  16'h1234, 16'h0000}, 1'b0, '{1'b0, 16'h0000}},
    '{'{lct_pkg::MODE_UNION_COVER, 4'd7,  4'd0,  16'h0000, 16'h0000}, 1'b0, '{1'b0, 16'h0000}},
    '{'{lct_pkg::MODE_ACK_ROW,     4'd15, 4'd0,  16'h0000, 16'h5555}, 1'b0, '{1'b0, 16'h0000}},
    '{'{lct_pkg::MODE_COVER,       4'd15, 4'd0,  16'h0000, 16'h0000}, 1'b0, '{1'b0, 16'h0000}},
    '{'{lct_pkg::MODE_EXPIRE,      4'd0,  4'd0,  16'h1238, 16'h0000}, 1'b0, '{1'b0, 16'h0000}},
    '{'{lct_pkg::MODE_READ_ROW,    4'd0,  4'd0,  16'h0000, 16'h0000}, 1'b0, '{1'b0, 16'h0000}}
  };

  // Apply one item to the shadow table and return the row report it causes
  function automatic report_t apply_link_event(item_t it);
    report_t r;
    logic [lct_pkg::HP_W-1:0] age;
    r.covered = 1'b0;
    case (it.mode)
      lct_pkg::MODE_HEARD_FROM: begin
        link_rows[own_slot][it.slot_id] = 1'b1;
        heard_hp[it.slot_id] = it.hyperperiod;
      end
      lct_pkg::MODE_ACK_ROW: begin
        link_rows[it.slot_id] = it.ack_row;
      end
      lct_pkg::MODE_COVER: begin
        r.covered = ((link_rows[own_slot] & ~link_rows[it.slot_id]) == '0);
      end
      lct_pkg::MODE_UNION_COVER: begin
        r.covered = ((link_rows[own_slot]
                      & ~(link_rows[it.slot_id] | link_rows[it.other_slot_id])) == '0);
      end
      lct_pkg::MODE_EXPIRE: begin
        for (int i = 0; i < NSLOT; i++) begin
          age = it.hyperperiod - heard_hp[i];
          if (i != own_slot && age > drop_limit) link_rows[own_slot][i] = 1'b0;
        end
      end
      default: ;
    endcase
    r.my_row = link_rows[own_slot];
    return r;
  endfunction

  // Drive one item until the block takes it, then log what it should return
  task automatic send_item(input item_t it, input logic typed, input report_t typed_rep);
    report_t predicted;
    item_ch.valid         <= 1'b1;
    item_ch.mode          <= it.mode;
    item_ch.slot_id       <= it.slot_id;
    item_ch.other_slot_id <= it.other_slot_id;
    item_ch.hyperperiod   <= it.hyperperiod;
    item_ch.ack_row       <= it.ack_row;
    do @(posedge clk); while (!item_ch.ready);
    predicted = apply_link_event(it);
    row_reports_q.push_back(typed ? typed_rep : predicted);
    outstanding++;
    mode_seen[it.mode]++;
  endtask

  // Random burst of idle cycles on the item side
  task automatic sender_gap();
    if (idle_on && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [lct_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [lct_pkg::CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    if (idx == lct_pkg::CFG_MY_SLOT) own_slot = data[lct_pkg::SLOT_W-1:0];
    else drop_limit = data;
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Result side readiness: random stall bursts while idling is on
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      res_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      res_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 17);
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest pending row report
  always @(posedge clk) begin : result_check
    report_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (row_reports_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: covered %0b row %h",
                   $realtime, res_ch.covered, res_ch.my_row_bits);
      end else begin
        want = row_reports_q.pop_front();
        outstanding--;
        if (res_ch.covered) covered_hits++;
        if (res_ch.covered !== want.covered || res_ch.my_row_bits !== want.my_row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch: covered exp %0b got %0b, my_row_bits exp %h got %h",
                     $realtime, want.covered, res_ch.covered, want.my_row, res_ch.my_row_bits);
        end
      end
    end
  end

  // Run limit
  initial begin
    #1_000_000;
    $display("[link_connectivity_table_unit] ERROR");
    $finish;
  end

  // Main sequence
  initial begin : main_seq
    item_t it;
    int sel;
    logic [lct_pkg::SLOT_W-1:0]  slot_pick;
    logic [lct_pkg::LIMIT_W-1:0] lim_pick;
    logic [11:0] junk;

    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_idx               = '0;
    cfg_data              = '0;
    item_ch.valid         = 1'b0;
    item_ch.mode          = '0;
    item_ch.slot_id       = '0;
    item_ch.other_slot_id = '0;
    item_ch.hyperperiod   = '0;
    item_ch.ack_row       = '0;
    outstanding           = 0;
    mismatches            = 0;
    covered_hits          = 0;
    settings_used         = 1;
    idle_on               = 1'b1;
    foreach (mode_seen[m]) mode_seen[m] = 0;
    own_slot   = lct_pkg::MY_SLOT_RST;
    drop_limit = lct_pkg::EXPIRE_LIMIT_RST;
    for (int i = 0; i < NSLOT; i++) begin
      link_rows[i] = '0;
      link_rows[i][i] = 1'b1;
      heard_hp[i] = '0;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed table under reset settings
    for (int k = 0; k < DIR_LEN; k++) begin
      sender_gap();
      send_item(directed_rows[k].it, directed_rows[k].typed, directed_rows[k].rep);
    end

    // Random phases, each under its own settings
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin slot_pick = 4'd15; lim_pick = 16'd0;      end
        1: begin slot_pick = 4'd0;  lim_pick = 16'hFFFF;   end
        2: begin slot_pick = 4'd7;  lim_pick = 16'd3;      end
        default: begin
          slot_pick = lct_pkg::SLOT_W'($urandom_range(0, NSLOT - 1));
          lim_pick  = ($urandom_range(0, 5) == 0)
                      ? lct_pkg::LIMIT_W'($urandom)
                      : lct_pkg::LIMIT_W'($urandom_range(0, 10));
        end
      endcase
      junk = 12'($urandom);
      write_reg(lct_pkg::CFG_MY_SLOT, {junk, slot_pick});
      write_reg(lct_pkg::CFG_EXPIRE_LIMIT, lim_pick);
      cfg_we <= 1'b0;
      settings_used++;
      // one calm early phase and a calm tail
      idle_on = (ph != 2 && ph != NUM_PHASES - 1);
      cur_hp  = lct_pkg::HP_W'($urandom);

      for (int n = 0; n < PHASE_LEN; n++) begin
        // hold off once until every pending report is back
        if (ph == 1 && n == PHASE_LEN / 2) drain_results();
        sender_gap();
        sel              = $urandom_range(0, 99);
        it.slot_id       = lct_pkg::SLOT_W'($urandom_range(0, NSLOT - 1));
        it.other_slot_id = lct_pkg::SLOT_W'($urandom_range(0, NSLOT - 1));
        it.hyperperiod   = cur_hp;
        it.ack_row       = lct_pkg::ACK_W'($urandom);
        if (sel < 30) begin
          it.mode = lct_pkg::MODE_HEARD_FROM;
          if ($urandom_range(0, 9) == 0) it.hyperperiod = lct_pkg::HP_W'($urandom);
        end else if (sel < 45) begin
          it.mode = lct_pkg::MODE_ACK_ROW;
          // acks for our own slot are rare noise
          if (it.slot_id == own_slot && $urandom_range(0, 3) != 0) it.slot_id++;
          if ($urandom_range(0, 1) == 0) it.ack_row = it.ack_row | link_rows[own_slot];
        end else if (sel < 60) begin
          it.mode = lct_pkg::MODE_COVER;
        end else if (sel < 75) begin
          it.mode = lct_pkg::MODE_UNION_COVER;
        end else if (sel < 88) begin
          it.mode = lct_pkg::MODE_EXPIRE;
          if ($urandom_range(0, 9) == 0) it.hyperperiod = lct_pkg::HP_W'($urandom);
        end else if (sel < 96) begin
          it.mode = lct_pkg::MODE_READ_ROW;
        end else begin
          it.mode = ($urandom_range(0, 1) == 0) ? MODE_SPARE_6 : MODE_SPARE_7;
        end
        send_item(it, 1'b0, '0);
        // time moves on slowly so links age past the limit
        if ($urandom_range(0, 3) == 0)
          cur_hp = cur_hp + lct_pkg::HP_W'($urandom_range(1, 3));
      end
    end

    // Wind down: all reports back, then room for a full expire scan
    drain_results();
    repeat (NSLOT + 4) @(posedge clk);
    $display("Ran heard_from %0d, ack_row %0d, cover %0d, union_cover %0d,",
             mode_seen[lct_pkg::MODE_HEARD_FROM], mode_seen[lct_pkg::MODE_ACK_ROW],
             mode_seen[lct_pkg::MODE_COVER], mode_seen[lct_pkg::MODE_UNION_COVER]);
    $display("  expire %0d, read_row %0d, unused codes %0d",
             mode_seen[lct_pkg::MODE_EXPIRE], mode_seen[lct_pkg::MODE_READ_ROW],
             mode_seen[MODE_SPARE_6] + mode_seen[MODE_SPARE_7]);
    $display("%0d register settings, %0d coverage answers true, %0d mismatches",
             settings_used, covered_hits, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[link_connectivity_table_unit] OK");
    end else begin
      $display("[link_connectivity_table_unit] ERROR");
    end
    $finish;
  end

endmodule
